@@ rtl/psi_pkg.sv @@
// Shared types, constants and saturation helper for the particle-source interaction core.
package psi_pkg;

    localparam int SQ_BITS  = 33;
    localparam int Q_BITS   = 41;
    localparam int PULL_CAP = 32;
    localparam int VEL_CAP  = 40;
    localparam int PIPE_LAT = 5 + (SQ_BITS + 1) + 2 + (Q_BITS + 1) + 2 + (Q_BITS + 1) + 1;

    localparam logic [31:0] GRAV_RESET = 32'h0001_0000;

    localparam logic signed [41:0] SAT_HI = 42'sd2147483647;
    localparam logic signed [41:0] SAT_LO = -42'sd2147483648;

    typedef struct packed {
        logic signed [31:0] source_x;
        logic signed [31:0] source_y;
        logic [31:0]        source_mass;
        logic [31:0]        source_radius;
        logic signed [31:0] part_x;
        logic signed [31:0] part_y;
        logic signed [31:0] part_vx;
        logic signed [31:0] part_vy;
        logic signed [31:0] part_ax;
        logic signed [31:0] part_ay;
        logic [31:0]        part_mass;
        logic [31:0]        part_radius;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] new_ax;
        logic signed [31:0] new_ay;
        logic signed [31:0] new_vx;
        logic signed [31:0] new_vy;
        logic               collided;
        logic               degenerate;
    } t_out_word;

    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic [31:0]        adx;
        logic [31:0]        ady;
        logic               dx_neg;
        logic               dy_neg;
        logic               dx_pos;
        logic               dy_pos;
        logic [31:0]        ms;
        logic [32:0]        mps;
        logic [63:0]        gm;
        logic [64:0]        dm;
        logic               dneg;
        logic [64:0]        dsq;
        logic               hit;
        logic               degen;
        logic [32:0]        root;
        logic signed [31:0] new_ax;
        logic signed [31:0] new_ay;
    } t_ctx;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] base,
                                                   input logic [40:0] mag,
                                                   input logic neg);
        logic signed [41:0] m;
        logic signed [41:0] s;
        m = $signed({1'b0, mag});
        s = $signed({{10{base[31]}}, base}) + (neg ? -m : m);
        if (s > SAT_HI) begin
            return 32'sh7FFF_FFFF;
        end else if (s < SAT_LO) begin
            return 32'sh8000_0000;
        end
        return s[31:0];
    endfunction

endpackage

@@ rtl/particle_source_interaction_core.sv @@
// Top level: gravity pull and elastic collision response for one particle-source pair per word.
//
// Input channel: a word is taken at a rising edge with start high and busy low.
// busy stays low, so a new pair can enter every cycle.
// Config: i_cfg_we writes i_cfg_wdata into the gravitational constant (Q16.16).
// Output channel: o_done marks o_result for exactly one cycle; the receiver
// cannot stall, so the pipeline never holds.
// Path from accept to o_done: the registered chain of a 33-stage
// square root, a 41-bit normal-impulse divider and a 41-bit projection divider,
// plus the multiply and add stages around them.
// Throughput: one word per cycle.
// Reset: i_rst_n low clears all valid bits and loads the constant with 1.0;
// words in flight are dropped.
module particle_source_interaction_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  psi_pkg::t_in_word   i_word,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_wdata,
    output logic                o_done,
    output psi_pkg::t_out_word  o_result
);
    import psi_pkg::*;

    logic [31:0] r_grav;

    logic        r_s1_vld;
    t_ctx        r_s1_ctx;
    logic [32:0] r_s1_dx;
    logic [32:0] r_s1_dy;
    logic [32:0] r_s1_rsum;

    logic        r_s2_vld;
    t_ctx        r_s2_ctx;
    logic [32:0] r_s2_rsum;
    logic [31:0] r_s2_avx;
    logic [31:0] r_s2_avy;
    logic        r_s2_vxn;
    logic        r_s2_vyn;

    logic        r_s3_vld;
    t_ctx        r_s3_ctx;
    logic [63:0] r_s3_sqx;
    logic [63:0] r_s3_sqy;
    logic [65:0] r_s3_rsq;
    logic [63:0] r_s3_m1;
    logic [63:0] r_s3_m2;
    logic        r_s3_s1;
    logic        r_s3_s2;

    logic        r_s4_vld;
    t_ctx        r_s4_ctx;
    logic [65:0] r_s4_rsq;

    logic        r_s5_vld;
    t_ctx        r_s5_ctx;

    logic        sq_vld;
    logic [32:0] sq_root;
    t_ctx        sq_ctx;

    logic        r_t1_vld;
    t_ctx        r_t1_ctx;
    logic [64:0] r_t1_dlo;
    logic [65:0] r_t1_dhi;
    logic [65:0] r_t1_den2;
    logic [63:0] r_t1_pxl;
    logic [63:0] r_t1_pxh;
    logic [63:0] r_t1_pyl;
    logic [63:0] r_t1_pyh;
    logic [63:0] r_t1_cl;
    logic [64:0] r_t1_ch;

    logic         r_t2_vld;
    t_ctx         r_t2_ctx;
    logic [97:0]  r_t2_den;
    logic [65:0]  r_t2_den2;
    logic [111:0] r_t2_numx;
    logic [111:0] r_t2_numy;
    logic [97:0]  r_t2_cnum;

    logic        pdx_vld;
    logic [32:0] pdx_q;
    t_ctx        pdx_ctx;
    logic [32:0] pdy_q;
    logic [40:0] f_q;

    logic        r_u1_vld;
    t_ctx        r_u1_ctx;
    logic [63:0] r_u1_fxl;
    logic [40:0] r_u1_fxh;
    logic [63:0] r_u1_fyl;
    logic [40:0] r_u1_fyh;

    logic        r_u2_vld;
    t_ctx        r_u2_ctx;
    logic [72:0] r_u2_numx;
    logic [72:0] r_u2_numy;

    logic        dvx_vld;
    logic [40:0] dvx_q;
    t_ctx        dvx_ctx;
    logic [40:0] dvy_q;

    logic        r_done;
    t_out_word   r_result;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav <= GRAV_RESET;
        end else if (i_cfg_we) begin
            r_grav <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
            r_t1_vld <= 1'b0;
            r_t2_vld <= 1'b0;
            r_u1_vld <= 1'b0;
            r_u2_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_s1_vld <= start && !busy;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
            r_s5_vld <= r_s4_vld;
            r_t1_vld <= sq_vld;
            r_t2_vld <= r_t1_vld;
            r_u1_vld <= pdx_vld;
            r_u2_vld <= r_u1_vld;
            r_done   <= dvx_vld;
        end
    end

    // differences and sums
    always_ff @(posedge i_clk) begin
        t_ctx c;
        c     = '0;
        c.ax  = i_word.part_ax;
        c.ay  = i_word.part_ay;
        c.vx  = i_word.part_vx;
        c.vy  = i_word.part_vy;
        c.ms  = i_word.source_mass;
        c.mps = {1'b0, i_word.part_mass} + {1'b0, i_word.source_mass};
        r_s1_ctx <= c;
        r_s1_dx <= {i_word.source_x[31], i_word.source_x}
                 - {i_word.part_x[31], i_word.part_x};
        r_s1_dy <= {i_word.source_y[31], i_word.source_y}
                 - {i_word.part_y[31], i_word.part_y};
        r_s1_rsum <= {1'b0, i_word.source_radius} + {1'b0, i_word.part_radius};
    end

    // magnitudes and signs
    always_ff @(posedge i_clk) begin
        logic [32:0] mx;
        logic [32:0] my;
        t_ctx        c;
        mx = r_s1_dx[32] ? (~r_s1_dx + 33'd1) : r_s1_dx;
        my = r_s1_dy[32] ? (~r_s1_dy + 33'd1) : r_s1_dy;
        c        = r_s1_ctx;
        c.adx    = mx[31:0];
        c.ady    = my[31:0];
        c.dx_neg = r_s1_dx[32];
        c.dy_neg = r_s1_dy[32];
        c.dx_pos = !r_s1_dx[32] && (r_s1_dx != '0);
        c.dy_pos = !r_s1_dy[32] && (r_s1_dy != '0);
        r_s2_ctx  <= c;
        r_s2_rsum <= r_s1_rsum;
        r_s2_avx  <= r_s1_ctx.vx[31] ? (~r_s1_ctx.vx + 32'd1) : r_s1_ctx.vx;
        r_s2_avy  <= r_s1_ctx.vy[31] ? (~r_s1_ctx.vy + 32'd1) : r_s1_ctx.vy;
        r_s2_vxn  <= r_s1_ctx.vx[31];
        r_s2_vyn  <= r_s1_ctx.vy[31];
    end

    // squares and products
    always_ff @(posedge i_clk) begin
        t_ctx c;
        c    = r_s2_ctx;
        c.gm = 64'(r_grav) * 64'(r_s2_ctx.ms);
        r_s3_ctx <= c;
        r_s3_sqx <= 64'(r_s2_ctx.adx) * 64'(r_s2_ctx.adx);
        r_s3_sqy <= 64'(r_s2_ctx.ady) * 64'(r_s2_ctx.ady);
        r_s3_rsq <= 66'(r_s2_rsum) * 66'(r_s2_rsum);
        r_s3_m1  <= 64'(r_s2_avx) * 64'(r_s2_ctx.adx);
        r_s3_m2  <= 64'(r_s2_avy) * 64'(r_s2_ctx.ady);
        r_s3_s1  <= r_s2_vxn != r_s2_ctx.dx_pos;
        r_s3_s2  <= r_s2_vyn != r_s2_ctx.dy_pos;
    end

    // distance squared and signed dot product
    always_ff @(posedge i_clk) begin
        t_ctx c;
        c     = r_s3_ctx;
        c.dsq = 65'(r_s3_sqx) + 65'(r_s3_sqy);
        if (r_s3_s1 == r_s3_s2) begin
            c.dm   = 65'(r_s3_m1) + 65'(r_s3_m2);
            c.dneg = r_s3_s1;
        end else if (r_s3_m1 >= r_s3_m2) begin
            c.dm   = 65'(r_s3_m1 - r_s3_m2);
            c.dneg = r_s3_s1;
        end else begin
            c.dm   = 65'(r_s3_m2 - r_s3_m1);
            c.dneg = r_s3_s2;
        end
        r_s4_ctx <= c;
        r_s4_rsq <= r_s3_rsq;
    end

    always_ff @(posedge i_clk) begin
        t_ctx c;
        c       = r_s4_ctx;
        c.hit   = r_s4_rsq >= 66'(r_s4_ctx.dsq);
        c.degen = r_s4_ctx.dsq == '0;
        r_s5_ctx <= c;
    end

    psi_sqrt #(
        .SB (SQ_BITS)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s5_vld),
        .i_sq    (r_s5_ctx.dsq),
        .i_side  (r_s5_ctx),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_ctx)
    );

    // partial products of the denominators and numerators
    always_ff @(posedge i_clk) begin
        t_ctx c;
        c      = sq_ctx;
        c.root = sq_root;
        r_t1_ctx  <= c;
        r_t1_dlo  <= 65'(sq_ctx.dsq[31:0]) * 65'(sq_root);
        r_t1_dhi  <= 66'(sq_ctx.dsq[64:32]) * 66'(sq_root);
        r_t1_den2 <= 66'(sq_ctx.mps) * 66'(sq_root);
        r_t1_pxl  <= 64'(sq_ctx.gm[31:0]) * 64'(sq_ctx.adx);
        r_t1_pxh  <= 64'(sq_ctx.gm[63:32]) * 64'(sq_ctx.adx);
        r_t1_pyl  <= 64'(sq_ctx.gm[31:0]) * 64'(sq_ctx.ady);
        r_t1_pyh  <= 64'(sq_ctx.gm[63:32]) * 64'(sq_ctx.ady);
        r_t1_cl   <= 64'(sq_ctx.ms) * 64'(sq_ctx.dm[31:0]);
        r_t1_ch   <= 65'(sq_ctx.ms) * 65'(sq_ctx.dm[64:32]);
    end

    always_ff @(posedge i_clk) begin
        r_t2_ctx  <= r_t1_ctx;
        r_t2_den  <= (98'(r_t1_dhi) << 32) + 98'(r_t1_dlo);
        r_t2_den2 <= r_t1_den2;
        r_t2_numx <= (112'(r_t1_pxh) << 48) + (112'(r_t1_pxl) << 16);
        r_t2_numy <= (112'(r_t1_pyh) << 48) + (112'(r_t1_pyl) << 16);
        r_t2_cnum <= (98'(r_t1_ch) << 33) + (98'(r_t1_cl) << 1);
    end

    psi_div #(
        .NW (112), .DW (98), .QB (Q_BITS), .CW (PULL_CAP)
    ) u_pdx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_t2_vld),
        .i_num   (r_t2_numx),
        .i_den   (r_t2_den),
        .i_side  (r_t2_ctx),
        .o_vld   (pdx_vld),
        .o_quo   (pdx_q),
        .o_side  (pdx_ctx)
    );

    psi_div #(
        .NW (112), .DW (98), .QB (Q_BITS), .CW (PULL_CAP)
    ) u_pdy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_t2_vld),
        .i_num   (r_t2_numy),
        .i_den   (r_t2_den),
        .i_side  (r_t2_ctx),
        .o_vld   (),
        .o_quo   (pdy_q),
        .o_side  ()
    );

    psi_div #(
        .NW (98), .DW (66), .QB (Q_BITS), .CW (VEL_CAP)
    ) u_fdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_t2_vld),
        .i_num   (r_t2_cnum),
        .i_den   (r_t2_den2),
        .i_side  (r_t2_ctx),
        .o_vld   (),
        .o_quo   (f_q),
        .o_side  ()
    );

    // apply pull, project normal impulse onto the axes
    always_ff @(posedge i_clk) begin
        t_ctx c;
        c        = pdx_ctx;
        c.new_ax = sat_add(pdx_ctx.ax, 41'(pdx_q), pdx_ctx.dx_neg);
        c.new_ay = sat_add(pdx_ctx.ay, 41'(pdy_q), pdx_ctx.dy_neg);
        r_u1_ctx <= c;
        r_u1_fxl <= 64'(f_q[31:0]) * 64'(pdx_ctx.adx);
        r_u1_fxh <= 41'(f_q[40:32]) * 41'(pdx_ctx.adx);
        r_u1_fyl <= 64'(f_q[31:0]) * 64'(pdx_ctx.ady);
        r_u1_fyh <= 41'(f_q[40:32]) * 41'(pdx_ctx.ady);
    end

    always_ff @(posedge i_clk) begin
        r_u2_ctx  <= r_u1_ctx;
        r_u2_numx <= (73'(r_u1_fxh) << 32) + 73'(r_u1_fxl);
        r_u2_numy <= (73'(r_u1_fyh) << 32) + 73'(r_u1_fyl);
    end

    psi_div #(
        .NW (73), .DW (33), .QB (Q_BITS), .CW (VEL_CAP)
    ) u_dvx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_u2_vld),
        .i_num   (r_u2_numx),
        .i_den   (r_u2_ctx.root),
        .i_side  (r_u2_ctx),
        .o_vld   (dvx_vld),
        .o_quo   (dvx_q),
        .o_side  (dvx_ctx)
    );

    psi_div #(
        .NW (73), .DW (33), .QB (Q_BITS), .CW (VEL_CAP)
    ) u_dvy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_u2_vld),
        .i_num   (r_u2_numy),
        .i_den   (r_u2_ctx.root),
        .i_side  (r_u2_ctx),
        .o_vld   (),
        .o_quo   (dvy_q),
        .o_side  ()
    );

    // output word
    always_ff @(posedge i_clk) begin
        logic neg_x;
        logic neg_y;
        neg_x = dvx_ctx.dneg != dvx_ctx.dx_pos;
        neg_y = dvx_ctx.dneg != dvx_ctx.dy_pos;
        if (dvx_ctx.degen) begin
            r_result.new_ax     <= dvx_ctx.ax;
            r_result.new_ay     <= dvx_ctx.ay;
            r_result.new_vx     <= dvx_ctx.vx;
            r_result.new_vy     <= dvx_ctx.vy;
            r_result.collided   <= 1'b1;
            r_result.degenerate <= 1'b1;
        end else begin
            r_result.new_ax     <= dvx_ctx.new_ax;
            r_result.new_ay     <= dvx_ctx.new_ay;
            r_result.new_vx     <= dvx_ctx.hit ? sat_add(dvx_ctx.vx, dvx_q, !neg_x)
                                               : dvx_ctx.vx;
            r_result.new_vy     <= dvx_ctx.hit ? sat_add(dvx_ctx.vy, dvy_q, !neg_y)
                                               : dvx_ctx.vy;
            r_result.collided   <= dvx_ctx.hit;
            r_result.degenerate <= 1'b0;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

@@ rtl/psi_sqrt.sv @@
// Pipelined integer square root, one result bit per stage, with context carried alongside.
module psi_sqrt #(
    parameter int SB = psi_pkg::SQ_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [2*SB-2:0]   i_sq,
    input  psi_pkg::t_ctx     i_side,
    output logic              o_vld,
    output logic [SB-1:0]     o_root,
    output psi_pkg::t_ctx     o_side
);
    import psi_pkg::*;

    localparam int TW = 2 * SB + 1;

    logic          r_vld  [SB+1];
    logic [TW-1:0] r_rem  [SB+1];
    logic [SB-1:0] r_res  [SB+1];
    t_ctx          r_side [SB+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
        r_rem[0]  <= TW'(i_sq);
        r_res[0]  <= '0;
        r_side[0] <= i_side;
    end

    for (genvar k = 0; k < SB; k++) begin : g_step
        localparam int BI = SB - 1 - k;
        logic [TW-1:0] trial;
        logic          ge;
        always_comb begin
            trial = (TW'(r_res[k]) << (BI + 1)) | (TW'(1) << (2 * BI));
            ge    = r_rem[k] >= trial;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
            r_rem[k+1]  <= ge ? r_rem[k] - trial : r_rem[k];
            r_res[k+1]  <= ge ? (r_res[k] | (SB'(1) << BI)) : r_res[k];
            r_side[k+1] <= r_side[k];
        end
    end

    assign o_vld  = r_vld[SB];
    assign o_root = r_res[SB];
    assign o_side = r_side[SB];

endmodule

@@ rtl/psi_div.sv @@
// Pipelined restoring divider with capped quotient and zero-divisor guard.
module psi_div #(
    parameter int NW = 112,
    parameter int DW = 98,
    parameter int QB = psi_pkg::Q_BITS,
    parameter int CW = psi_pkg::PULL_CAP
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  psi_pkg::t_ctx i_side,
    output logic          o_vld,
    output logic [CW:0]   o_quo,
    output psi_pkg::t_ctx o_side
);
    import psi_pkg::*;

    localparam logic [QB-1:0] CAP_Q = QB'(1) << CW;

    logic          r_vld  [QB+1];
    logic [DW-1:0] r_rem  [QB+1];
    logic [DW-1:0] r_dv   [QB+1];
    logic [QB-1:0] r_lo   [QB+1];
    logic [QB-1:0] r_q    [QB+1];
    logic          r_ovf  [QB+1];
    logic          r_zero [QB+1];
    t_ctx          r_side [QB+1];

    logic [NW-QB-1:0] num_hi;
    assign num_hi = i_num[NW-1:QB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
        r_rem[0]  <= DW'(num_hi);
        r_dv[0]   <= i_den;
        r_lo[0]   <= i_num[QB-1:0];
        r_q[0]    <= '0;
        r_ovf[0]  <= DW'(num_hi) >= i_den;
        r_zero[0] <= i_den == '0;
        r_side[0] <= i_side;
    end

    for (genvar k = 0; k < QB; k++) begin : g_step
        logic [DW:0] shifted;
        logic [DW:0] diff;
        logic        ge;
        always_comb begin
            shifted = {r_rem[k], r_lo[k][QB-1]};
            diff    = shifted - {1'b0, r_dv[k]};
            ge      = shifted >= {1'b0, r_dv[k]};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
            r_rem[k+1]  <= ge ? diff[DW-1:0] : shifted[DW-1:0];
            r_dv[k+1]   <= r_dv[k];
            r_lo[k+1]   <= {r_lo[k][QB-2:0], 1'b0};
            r_q[k+1]    <= {r_q[k][QB-2:0], ge};
            r_ovf[k+1]  <= r_ovf[k];
            r_zero[k+1] <= r_zero[k];
            r_side[k+1] <= r_side[k];
        end
    end

    always_comb begin
        if (r_zero[QB]) begin
            o_quo = '0;
        end else if (r_ovf[QB] || (r_q[QB] > CAP_Q)) begin
            o_quo = CAP_Q[CW:0];
        end else begin
            o_quo = r_q[QB][CW:0];
        end
    end

    assign o_vld  = r_vld[QB];
    assign o_side = r_side[QB];

endmodule

@@ rtl/psi_checker.sv @@
// Port-level checks for the particle-source interaction core, bound to the top level.
module psi_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input psi_pkg::t_in_word  i_word,
    input logic               i_cfg_we,
    input logic [31:0]        i_cfg_wdata,
    input logic               o_done,
    input psi_pkg::t_out_word o_result
);
    import psi_pkg::*;

    logic acc;
    assign acc = start && !busy;

    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |-> ##PIPE_LAT o_done)
        else $error("accepted word did not complete at fixed latency");

    a_lat_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(acc, PIPE_LAT))
        else $error("result word without matching accept");

    a_degen_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.degenerate) |-> o_result.collided)
        else $error("degenerate word not flagged as collided");

    a_degen_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.degenerate) |->
            (o_result.new_vx == $past(i_word.part_vx, PIPE_LAT))
            && (o_result.new_ax == $past(i_word.part_ax, PIPE_LAT)))
        else $error("degenerate word did not pass through");

endmodule

bind particle_source_interaction_core psi_checker u_chk (.*);

@@ tb/sv/psi_checker.sv @@
// Checker: predicts each result word of the interaction core and compares it with the output.
module psi_scoreboard (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  psi_pkg::t_in_word   i_word,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_wdata,
    input  logic                i_done,
    input  psi_pkg::t_out_word  i_result,
    output int                  o_errors,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import psi_pkg::*;

    logic [31:0] grav;
    t_out_word   expected_words[$];

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [127:0] capped_div(logic [127:0] n, logic [127:0] d,
                                                logic [127:0] cap);
        logic [127:0] q;
        if (d == 0) return 0;
        q = n / d;
        return (q > cap) ? cap : q;
    endfunction

    function automatic t_out_word interact(t_in_word w, logic [31:0] g);
        t_out_word o;
        longint sx, sy, px, py, vx, vy, ax, ay, dx, dy, px_pull, py_pull, dlx, dly;
        logic [127:0] adx, ady, avx, avy, dd, r, c, den, gm, q, rsum, m1, m2, dm, f, dl;
        logic s1, s2, dneg, hit, uxn, uyn;
        sx = w.source_x; sy = w.source_y; px = w.part_x; py = w.part_y;
        vx = w.part_vx; vy = w.part_vy; ax = w.part_ax; ay = w.part_ay;
        dx = sx - px; dy = sy - py;
        adx = 128'(dx < 0 ? -dx : dx);
        ady = 128'(dy < 0 ? -dy : dy);
        dd = adx * adx + ady * ady;
        if (dd == 0) begin
            o.new_ax = w.part_ax; o.new_ay = w.part_ay;
            o.new_vx = w.part_vx; o.new_vy = w.part_vy;
            o.collided = 1'b1; o.degenerate = 1'b1;
            return o;
        end
        r = 0;
        for (int b = 34; b >= 0; b--) begin
            c = r | (128'd1 << b);
            if (c * c <= dd) r = c;
        end
        den = dd * r;
        gm = 128'(g) * 128'(w.source_mass);
        q = capped_div(gm * (adx << 16), den, 128'h1_0000_0000);
        px_pull = longint'(q);
        o.new_ax = 32'(clamp32(ax + (dx < 0 ? -px_pull : px_pull)));
        q = capped_div(gm * (ady << 16), den, 128'h1_0000_0000);
        py_pull = longint'(q);
        o.new_ay = 32'(clamp32(ay + (dy < 0 ? -py_pull : py_pull)));
        rsum = 128'(w.source_radius) + 128'(w.part_radius);
        hit = (rsum * rsum >= dd);
        o.collided = hit;
        o.degenerate = 1'b0;
        o.new_vx = w.part_vx;
        o.new_vy = w.part_vy;
        if (hit) begin
            uxn = (dx > 0);
            uyn = (dy > 0);
            avx = 128'(vx < 0 ? -vx : vx);
            avy = 128'(vy < 0 ? -vy : vy);
            m1 = avx * adx; m2 = avy * ady;
            s1 = (vx < 0) != uxn;
            s2 = (vy < 0) != uyn;
            if (s1 == s2) begin
                dm = m1 + m2; dneg = s1;
            end else if (m1 >= m2) begin
                dm = m1 - m2; dneg = s1;
            end else begin
                dm = m2 - m1; dneg = s2;
            end
            f = capped_div(128'(w.source_mass) * 2 * dm,
                           (128'(w.part_mass) + 128'(w.source_mass)) * r, 128'h100_0000_0000);
            dl = capped_div(f * adx, r, 128'h100_0000_0000);
            dlx = longint'(dl);
            dl = capped_div(f * ady, r, 128'h100_0000_0000);
            dly = longint'(dl);
            o.new_vx = 32'(clamp32(vx - ((dneg != uxn) ? -dlx : dlx)));
            o.new_vy = 32'(clamp32(vy - ((dneg != uyn) ? -dly : dly)));
        end
        return o;
    endfunction

    always @(posedge i_clk) begin
        t_out_word e;
        int        n;
        n = 0;
        if (!i_rst_n) begin
            grav <= GRAV_RESET;
            o_errors <= 0;
            o_pending <= 0;
            expected_words.delete();
        end else begin
            if (i_cfg_we) grav <= i_cfg_wdata;
            if (i_start && !i_busy) expected_words.push_back(interact(i_word, grav));
            if (i_done) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected result word");
                    n++;
                end else begin
                    e = expected_words.pop_front();
                    if (e.new_ax !== i_result.new_ax) begin
                        $error("new_ax exp %h got %h", e.new_ax, i_result.new_ax);
                        n++;
                    end
                    if (e.new_ay !== i_result.new_ay) begin
                        $error("new_ay exp %h got %h", e.new_ay, i_result.new_ay);
                        n++;
                    end
                    if (e.new_vx !== i_result.new_vx) begin
                        $error("new_vx exp %h got %h", e.new_vx, i_result.new_vx);
                        n++;
                    end
                    if (e.new_vy !== i_result.new_vy) begin
                        $error("new_vy exp %h got %h", e.new_vy, i_result.new_vy);
                        n++;
                    end
                    if (e.collided !== i_result.collided) begin
                        $error("collided exp %b got %b", e.collided, i_result.collided);
                        n++;
                    end
                    if (e.degenerate !== i_result.degenerate) begin
                        $error("degenerate exp %b got %b", e.degenerate, i_result.degenerate);
                        n++;
                    end
                end
            end
            o_errors <= o_errors + n;
            o_pending <= expected_words.size();
        end
    end
endmodule

@@ tb/sv/tb_top.sv @@
// Testbench top: drives pair words and constant writes into the core and reports the verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import psi_pkg::*;

    localparam int LIMIT = 400000;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_in_word   i_word;
    logic       i_cfg_we;
    logic [31:0] i_cfg_wdata;
    logic       o_done;
    t_out_word  o_result;
    int         errors;
    int         pending;
    int         cycles;

    particle_source_interaction_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_word(i_word),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata), .o_done(o_done), .o_result(o_result)
    );

    psi_scoreboard u_scoreboard (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy), .i_word(i_word),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata), .i_done(o_done),
        .i_result(o_result), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    function automatic logic [31:0] rnd32();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] spread();
        int s;
        s = $urandom_range(4, 31);
        return $urandom() & ((32'h1 << s) - 1);
    endfunction

    // mostly near pairs with radii that reach, so collisions are common
    function automatic t_in_word pair_word();
        t_in_word w;
        w.source_x = $urandom(); w.source_y = $urandom();
        w.source_mass = $urandom(); w.source_radius = $urandom();
        w.part_x = $urandom(); w.part_y = $urandom();
        w.part_vx = $urandom(); w.part_vy = $urandom();
        w.part_ax = $urandom(); w.part_ay = $urandom();
        w.part_mass = $urandom(); w.part_radius = $urandom();
        case ($urandom_range(0, 9))
            0, 1: ;
            2: begin
                w.source_mass = rnd32(); w.part_ax = rnd32(); w.part_ay = rnd32();
                w.part_vx = rnd32(); w.part_vy = rnd32();
            end
            3: begin
                w.part_x = w.source_x; w.part_y = w.source_y;
            end
            default: begin
                w.part_x = w.source_x + $signed(spread()) - $signed(spread());
                w.part_y = w.source_y + $signed(spread()) - $signed(spread());
                w.source_radius = spread(); w.part_radius = spread();
                if ($urandom_range(0, 3) == 0) w.part_mass = spread();
                if ($urandom_range(0, 3) == 0) w.source_mass = spread();
                if ($urandom_range(0, 7) == 0) begin
                    w.part_mass = 0; w.source_mass = 0;
                end
            end
        endcase
        return w;
    endfunction

    task automatic send(input t_in_word w);
        start <= 1'b1;
        i_word <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic pause(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        pause(1);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_grav(input logic [31:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic directed();
        t_in_word w;
        w = '0;
        send(w);                                   // zero distance
        w.part_ax = 32'sh7FFF_FFFF; w.part_vx = 32'sh8000_0000;
        send(w);
        w = '0;
        w.source_x = 32'sh7FFF_FFFF; w.part_x = 32'sh8000_0000;
        w.source_y = 32'sh8000_0000; w.part_y = 32'sh7FFF_FFFF;
        w.source_mass = '1; w.part_ax = 32'sh7FFF_FFF0; w.part_ay = 32'sh8000_0010;
        send(w);
        w.source_radius = '1; w.part_radius = '1;
        w.part_vx = 32'sh7FFF_FFFF; w.part_vy = 32'sh8000_0000; w.part_mass = 0;
        send(w);
        w = '0;
        w.source_x = 32'h0001_0000; w.source_mass = 32'h0010_0000;
        w.source_radius = 32'h0001_0000; w.part_vx = 32'h0002_0000;
        w.part_mass = 32'h0001_0000;
        send(w);                                   // contact exactly at the radius sum
        w.source_radius = 32'h0000_FFFF;
        send(w);                                   // just apart
        w.source_radius = 32'h0002_0000; w.source_mass = 0; w.part_mass = 0;
        send(w);                                   // both masses zero
        w.source_mass = '1; w.part_mass = '1; w.part_vx = 32'sh8000_0000;
        w.part_vy = 32'sh7FFF_FFFF; w.source_y = 32'h0000_0001;
        send(w);
        w.source_x = 1; w.source_y = 0; w.part_ax = 32'sh8000_0000;
        send(w);
        repeat (12) send(pair_word());
    endtask

    task automatic random_phase(input int n, input bit idle);
        for (int k = 0; k < n; k++) begin
            if (idle && $urandom_range(0, 5) == 0) pause($urandom_range(1, 15));
            send(pair_word());
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_word = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed();
        random_phase(200, 1);
        drain();
        write_grav(32'h0);
        directed();
        random_phase(200, 1);
        drain();
        write_grav(32'hFFFF_FFFF);
        directed();
        random_phase(250, 1);
        drain();
        write_grav($urandom());
        random_phase(250, 1);
        drain();
        write_grav(GRAV_RESET);
        random_phase(200, 1);
        random_phase(120, 0);
        drain();
        repeat (PIPE_LAT + 20) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule

@@ files.f @@
rtl/psi_pkg.sv
rtl/psi_sqrt.sv
rtl/psi_div.sv
rtl/particle_source_interaction_core.sv
rtl/psi_checker.sv
tb/sv/psi_checker.sv
tb/sv/tb_top.sv
